@@ hdl/crc16_pkg.sv @@
package crc16_pkg;

    localparam int CRC_WIDTH  = 16;
    localparam int DATA_WIDTH = 8;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CRC_WIDTH-1:0] CRC_TOP_BIT = 16'h8000;
    localparam logic [CRC_WIDTH-1:0] CRC_LOW_BIT = 16'h0001;

    localparam logic [CRC_WIDTH-1:0] POLYNOMIAL_RESET  = 16'h8005;
    localparam logic                 REFLECTED_RESET   = 1'b1;
    localparam logic [CRC_WIDTH-1:0] START_VALUE_RESET = 16'hFFFF;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_POLYNOMIAL  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_REFLECTED   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_VALUE = 2'd2;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] data_byte;
        logic                  first_byte;
        logic                  last_byte;
    } in_word_t;

    typedef struct packed {
        logic [CRC_WIDTH-1:0] crc_value;
        logic                 message_done;
    } out_word_t;

endpackage

@@ hdl/crc16_configurable.sv @@
// An accepted word sits in the input register; its CRC is then registered onto m_data.
// Throughput: one byte per cycle unless m_ready stalls the result register; the eight bit
// steps of a byte form one XOR network between the input register and the result register.
// While the result register waits on m_ready, an empty input stage still accepts a new word.
// Reset (aresetn low, synchronous): both stages empty, running CRC zero,
// polynomial 0x8005, reflected mode on, start value 0xFFFF.
module crc16_configurable (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [crc16_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [crc16_pkg::CRC_WIDTH-1:0]       cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  crc16_pkg::in_word_t                   s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output crc16_pkg::out_word_t                  m_data
);
    import crc16_pkg::*;

    logic [CRC_WIDTH-1:0] polynomial_reg;
    logic                 reflected_reg;
    logic [CRC_WIDTH-1:0] start_value_reg;
    logic [CRC_WIDTH-1:0] crc_reg;
    logic [CRC_WIDTH-1:0] crc_next;
    logic                 in_valid_reg;
    in_word_t             in_reg;
    logic                 out_valid_reg;
    out_word_t            out_reg;
    logic                 advance;

    function automatic logic [CRC_WIDTH-1:0] fold_byte(
        input logic [CRC_WIDTH-1:0]  crc_in,
        input logic [DATA_WIDTH-1:0] data,
        input logic [CRC_WIDTH-1:0]  poly,
        input logic                  refl
    );
        logic [CRC_WIDTH-1:0] crc;
        logic [CRC_WIDTH-1:0] poly_rev;
        logic                 fb;
        crc = crc_in;
        for (int k = 0; k < CRC_WIDTH; k++) begin
            poly_rev[k] = poly[CRC_WIDTH-1-k];
        end
        for (int k = 0; k < DATA_WIDTH; k++) begin
            if (refl) begin
                fb  = ((crc & CRC_LOW_BIT) != '0) ^ data[k];
                crc = crc >> 1;
                if (fb) begin
                    crc = crc ^ poly_rev;
                end
            end else begin
                fb  = ((crc & CRC_TOP_BIT) != '0) ^ data[DATA_WIDTH-1-k];
                crc = crc << 1;
                if (fb) begin
                    crc = crc ^ poly;
                end
            end
        end
        return crc;
    endfunction

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        crc_next = fold_byte(in_reg.first_byte ? start_value_reg : crc_reg,
                             in_reg.data_byte, polynomial_reg, reflected_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            polynomial_reg  <= POLYNOMIAL_RESET;
            reflected_reg   <= REFLECTED_RESET;
            start_value_reg <= START_VALUE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_POLYNOMIAL:  polynomial_reg  <= cfg_wdata;
                REG_REFLECTED:   reflected_reg   <= cfg_wdata[0];
                REG_START_VALUE: start_value_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                crc_reg       <= crc_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg.crc_value    <= crc_next;
            out_reg.message_done <= in_reg.last_byte;
        end
    end

    a_result_follows_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result register empty after advance");

    a_output_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.crc_value == crc_reg))
        else $error("result word differs from running CRC");

    a_done_tracks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (out_reg.message_done == $past(in_reg.last_byte)))
        else $error("message_done does not follow last_byte");

    a_input_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input stage dropped a word while stalled");

endmodule
